@@ hdl/rfbd_pkg.sv @@
// shared constants and types for the reply frame boundary detector
package rfbd_pkg;

  // default header / counter width
  localparam int NUMBER_BITS_DEF = 25;

  // frame byte limit register
  localparam int LIMIT_W = 25;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 25'd1048576;
  localparam logic [LIMIT_W-1:0] LIMIT_ONE   = 25'd1;

  // configuration port
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = 1;
  localparam logic [REG_IDX_W-1:0] REG_MAX_FRAME_BYTES = 1'b0;

  // stream fields
  localparam int BYTE_W = 8;
  localparam int KIND_W = 3;

  // frame kinds
  localparam logic [KIND_W-1:0] KIND_SIMPLE  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_ERROR   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_INTEGER = 3'd2;
  localparam logic [KIND_W-1:0] KIND_BULK    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_ARRAY   = 3'd4;

  // protocol characters
  localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_PLUS   = 8'h2B;
  localparam logic [BYTE_W-1:0] CH_MINUS  = 8'h2D;
  localparam logic [BYTE_W-1:0] CH_COLON  = 8'h3A;
  localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
  localparam logic [BYTE_W-1:0] CH_STAR   = 8'h2A;
  localparam logic [BYTE_W-1:0] CH_ZERO   = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE   = 8'h39;

  // parser phase, one-hot
  typedef enum logic [8:0] {
    PH_TYPE      = 9'b000000001,
    PH_LINE      = 9'b000000010,
    PH_BULK_HDR  = 9'b000000100,
    PH_ARR_HDR   = 9'b000001000,
    PH_ITEM_TYPE = 9'b000010000,
    PH_ITEM_HDR  = 9'b000100000,
    PH_BULK_BODY = 9'b001000000,
    PH_ITEM_BODY = 9'b010000000,
    PH_STUCK     = 9'b100000000
  } phase_t;

endpackage

@@ hdl/rfbd_byte_if.sv @@
// byte stream channel: valid, ready and one raw byte
interface rfbd_byte_if;
  logic                           valid;
  logic                           ready;
  logic [rfbd_pkg::BYTE_W-1:0]    data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

@@ hdl/rfbd_result_if.sv @@
// result channel: valid, ready and the per-byte frame status
interface rfbd_result_if;
  logic                           valid;
  logic                           ready;
  logic                           frame_done;
  logic [rfbd_pkg::KIND_W-1:0]    frame_kind;
  logic                           null_bulk;
  logic                           stuck;
  logic                           oversize;

  modport source (output valid, output frame_done, output frame_kind, output null_bulk,
                  output stuck, output oversize, input ready);
  modport sink (input valid, input frame_done, input frame_kind, input null_bulk,
                input stuck, input oversize, output ready);
endinterface

@@ hdl/resp_frame_boundary_detector.sv @@
// top level: reply frame boundary detector with register port
//
// Takes one reply stream byte per transaction and returns one status transaction per byte:
// whether the byte completes a reply frame, the frame kind, null bulk, stuck and the
// latched oversize error. Throughput is one byte per clock cycle while frame_info takes each
// status; each status appears in the cycle after its byte is accepted, from a single output
// register. byte_stream.ready drops only while that register holds a status that frame_info has
// not taken. The frame limit register (address 0) should be written only while the stream is
// idle; oversize and stuck clear only on reset.
module resp_frame_boundary_detector #(
  parameter int NUMBER_BITS = rfbd_pkg::NUMBER_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [rfbd_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [rfbd_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [rfbd_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready,
  rfbd_byte_if.sink                         byte_stream,
  rfbd_result_if.source                     frame_info
);

  localparam logic [NUMBER_BITS-1:0] NUM_ZERO = '0;
  localparam logic [NUMBER_BITS-1:0] NUM_ONE  = NUMBER_BITS'(1);
  localparam logic [NUMBER_BITS-1:0] NUM_TWO  = NUMBER_BITS'(2);
  localparam logic [NUMBER_BITS-1:0] NUM_MAX  = '1;

  // state registers
  rfbd_pkg::phase_t                 phase, phase_next;
  logic [rfbd_pkg::KIND_W-1:0]      kind_reg, kind_reg_next;
  logic                             saw_cr, saw_cr_next;
  logic                             header_negative, header_negative_next;
  logic                             header_digit_seen, header_digit_seen_next;
  logic [NUMBER_BITS-1:0]           header_value, header_value_next;
  logic [NUMBER_BITS-1:0]           payload_left, payload_left_next;
  logic [NUMBER_BITS-1:0]           items_left, items_left_next;
  logic [rfbd_pkg::LIMIT_W-1:0]     frame_bytes, frame_bytes_next;
  logic                             stuck_flag, stuck_flag_next;
  logic                             oversize_latch, oversize_latch_next;
  logic [rfbd_pkg::LIMIT_W-1:0]     max_frame_bytes;

  // result register
  logic                             out_valid;
  logic                             out_done, out_done_next;
  logic [rfbd_pkg::KIND_W-1:0]      out_kind;
  logic                             out_null, out_null_next;

  logic                             in_fire;
  logic                             cfg_write;
  logic                             cfg_hit;
  logic [rfbd_pkg::BYTE_W-1:0]      b;

  // header parse helpers
  logic                             is_digit;
  logic [NUMBER_BITS+3:0]           hv_ext;
  logic [NUMBER_BITS+3:0]           hv_x10;
  logic [NUMBER_BITS-1:0]           hv_sat;
  logic [NUMBER_BITS:0]             hv_plus2_ext;
  logic [NUMBER_BITS-1:0]           hv_plus2;
  logic                             hdr_bad;
  logic                             hdr_end;
  logic                             hdr_saw_cr;
  logic                             hdr_negative;
  logic                             hdr_digit_seen;
  logic [NUMBER_BITS-1:0]           hdr_value;
  logic [NUMBER_BITS-1:0]           payload_dec;
  logic [NUMBER_BITS-1:0]           items_dec;

  // handshakes
  assign in_fire = byte_stream.valid && byte_stream.ready;
  assign byte_stream.ready = !out_valid || frame_info.ready;
  assign b = byte_stream.data_byte;

  // register port
  assign pready    = 1'b1;
  assign cfg_hit   = (paddr[rfbd_pkg::APB_ADDR_W-1:2] == rfbd_pkg::REG_MAX_FRAME_BYTES);
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    if (cfg_hit) begin
      prdata = {{(rfbd_pkg::APB_DATA_W-rfbd_pkg::LIMIT_W){1'b0}}, max_frame_bytes};
    end else begin
      prdata = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_frame_bytes <= rfbd_pkg::LIMIT_RESET;
    end else if (cfg_write && cfg_hit) begin
      max_frame_bytes <= pwdata[rfbd_pkg::LIMIT_W-1:0];
    end
  end

  // decimal accumulate with saturation, and length plus trailer
  assign is_digit     = (b >= rfbd_pkg::CH_ZERO) && (b <= rfbd_pkg::CH_NINE);
  assign hv_ext       = {4'b0000, header_value};
  assign hv_x10       = (hv_ext << 3) + (hv_ext << 1) + {{NUMBER_BITS{1'b0}}, b[3:0]};
  assign hv_sat       = (hv_x10[NUMBER_BITS+3:NUMBER_BITS] != 4'b0000) ? NUM_MAX
                                                                      : hv_x10[NUMBER_BITS-1:0];
  assign hv_plus2_ext = {1'b0, header_value} + {1'b0, NUM_TWO};
  assign hv_plus2     = hv_plus2_ext[NUMBER_BITS] ? NUM_MAX : hv_plus2_ext[NUMBER_BITS-1:0];
  assign payload_dec  = (payload_left != NUM_ZERO) ? payload_left - NUM_ONE : payload_left;
  assign items_dec    = (items_left != NUM_ZERO) ? items_left - NUM_ONE : items_left;

  // header byte: length digits, optional leading minus, then cr lf
  always_comb begin
    hdr_bad        = 1'b0;
    hdr_end        = 1'b0;
    hdr_saw_cr     = saw_cr;
    hdr_negative   = header_negative;
    hdr_digit_seen = header_digit_seen;
    hdr_value      = header_value;
    if (saw_cr) begin
      if (b == rfbd_pkg::CH_LF && header_digit_seen) begin
        hdr_end = 1'b1;
      end else begin
        hdr_bad = 1'b1;
      end
    end else if (b == rfbd_pkg::CH_CR) begin
      hdr_saw_cr = 1'b1;
    end else if (b == rfbd_pkg::CH_MINUS && !header_digit_seen && !header_negative) begin
      hdr_negative = 1'b1;
    end else if (is_digit) begin
      hdr_value      = hv_sat;
      hdr_digit_seen = 1'b1;
    end else begin
      hdr_bad = 1'b1;
    end
  end

  // frame parser next state for the byte at the input
  always_comb begin
    phase_next             = phase;
    kind_reg_next          = kind_reg;
    saw_cr_next            = saw_cr;
    header_negative_next   = header_negative;
    header_digit_seen_next = header_digit_seen;
    header_value_next      = header_value;
    payload_left_next      = payload_left;
    items_left_next        = items_left;
    frame_bytes_next       = frame_bytes;
    stuck_flag_next        = stuck_flag;
    oversize_latch_next    = oversize_latch;
    out_done_next          = 1'b0;
    out_null_next          = 1'b0;

    if (!oversize_latch) begin
      if (frame_bytes >= max_frame_bytes) begin
        oversize_latch_next = 1'b1;
      end else begin
        frame_bytes_next = frame_bytes + rfbd_pkg::LIMIT_ONE;
        unique case (phase) inside
          rfbd_pkg::PH_TYPE: begin
            saw_cr_next            = 1'b0;
            header_negative_next   = 1'b0;
            header_digit_seen_next = 1'b0;
            header_value_next      = NUM_ZERO;
            if (b == rfbd_pkg::CH_PLUS) begin
              kind_reg_next = rfbd_pkg::KIND_SIMPLE;
              phase_next    = rfbd_pkg::PH_LINE;
            end else if (b == rfbd_pkg::CH_MINUS) begin
              kind_reg_next = rfbd_pkg::KIND_ERROR;
              phase_next    = rfbd_pkg::PH_LINE;
            end else if (b == rfbd_pkg::CH_COLON) begin
              kind_reg_next = rfbd_pkg::KIND_INTEGER;
              phase_next    = rfbd_pkg::PH_LINE;
            end else if (b == rfbd_pkg::CH_DOLLAR) begin
              kind_reg_next = rfbd_pkg::KIND_BULK;
              phase_next    = rfbd_pkg::PH_BULK_HDR;
            end else if (b == rfbd_pkg::CH_STAR) begin
              kind_reg_next = rfbd_pkg::KIND_ARRAY;
              phase_next    = rfbd_pkg::PH_ARR_HDR;
            end else begin
              kind_reg_next   = rfbd_pkg::KIND_SIMPLE;
              stuck_flag_next = 1'b1;
              phase_next      = rfbd_pkg::PH_STUCK;
            end
          end
          rfbd_pkg::PH_LINE: begin
            if (saw_cr && b == rfbd_pkg::CH_LF) begin
              out_done_next = 1'b1;
            end else begin
              saw_cr_next = (b == rfbd_pkg::CH_CR);
            end
          end
          rfbd_pkg::PH_BULK_HDR: begin
            saw_cr_next            = hdr_saw_cr;
            header_negative_next   = hdr_negative;
            header_digit_seen_next = hdr_digit_seen;
            header_value_next      = hdr_value;
            if (hdr_bad) begin
              stuck_flag_next = 1'b1;
              phase_next      = rfbd_pkg::PH_STUCK;
            end else if (hdr_end) begin
              if (header_negative && header_value == NUM_ONE) begin
                out_done_next = 1'b1;
                out_null_next = 1'b1;
              end else if (header_negative && header_value != NUM_ZERO) begin
                stuck_flag_next = 1'b1;
                phase_next      = rfbd_pkg::PH_STUCK;
              end else begin
                payload_left_next = hv_plus2;
                phase_next        = rfbd_pkg::PH_BULK_BODY;
              end
            end
          end
          rfbd_pkg::PH_ARR_HDR, rfbd_pkg::PH_ITEM_HDR: begin
            saw_cr_next            = hdr_saw_cr;
            header_negative_next   = hdr_negative;
            header_digit_seen_next = hdr_digit_seen;
            header_value_next      = hdr_value;
            if (hdr_bad || (hdr_end && header_negative && header_value != NUM_ZERO)) begin
              stuck_flag_next = 1'b1;
              phase_next      = rfbd_pkg::PH_STUCK;
            end else if (hdr_end) begin
              if (phase == rfbd_pkg::PH_ARR_HDR) begin
                items_left_next = header_value;
                if (header_value == NUM_ZERO) begin
                  out_done_next = 1'b1;
                end else begin
                  phase_next = rfbd_pkg::PH_ITEM_TYPE;
                end
              end else begin
                payload_left_next = hv_plus2;
                phase_next        = rfbd_pkg::PH_ITEM_BODY;
              end
            end
          end
          rfbd_pkg::PH_ITEM_TYPE: begin
            saw_cr_next            = 1'b0;
            header_negative_next   = 1'b0;
            header_digit_seen_next = 1'b0;
            header_value_next      = NUM_ZERO;
            if (b == rfbd_pkg::CH_DOLLAR) begin
              phase_next = rfbd_pkg::PH_ITEM_HDR;
            end else begin
              stuck_flag_next = 1'b1;
              phase_next      = rfbd_pkg::PH_STUCK;
            end
          end
          rfbd_pkg::PH_BULK_BODY, rfbd_pkg::PH_ITEM_BODY: begin
            payload_left_next = payload_dec;
            if (payload_dec == NUM_ZERO) begin
              if (phase == rfbd_pkg::PH_BULK_BODY) begin
                out_done_next = 1'b1;
              end else begin
                items_left_next = items_dec;
                if (items_dec == NUM_ZERO) begin
                  out_done_next = 1'b1;
                end else begin
                  phase_next = rfbd_pkg::PH_ITEM_TYPE;
                end
              end
            end
          end
          default: begin
            stuck_flag_next = 1'b1;
            phase_next      = rfbd_pkg::PH_STUCK;
          end
        endcase
      end
    end
  end

  // parser state, cleared for the next frame on completion
  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= rfbd_pkg::PH_TYPE;
      kind_reg          <= rfbd_pkg::KIND_SIMPLE;
      saw_cr            <= 1'b0;
      header_negative   <= 1'b0;
      header_digit_seen <= 1'b0;
      header_value      <= NUM_ZERO;
      payload_left      <= NUM_ZERO;
      items_left        <= NUM_ZERO;
      frame_bytes       <= '0;
      stuck_flag        <= 1'b0;
      oversize_latch    <= 1'b0;
    end else if (in_fire) begin
      stuck_flag     <= stuck_flag_next;
      oversize_latch <= oversize_latch_next;
      if (out_done_next) begin
        phase             <= rfbd_pkg::PH_TYPE;
        kind_reg          <= rfbd_pkg::KIND_SIMPLE;
        saw_cr            <= 1'b0;
        header_negative   <= 1'b0;
        header_digit_seen <= 1'b0;
        header_value      <= NUM_ZERO;
        payload_left      <= NUM_ZERO;
        items_left        <= NUM_ZERO;
        frame_bytes       <= '0;
      end else begin
        phase             <= phase_next;
        kind_reg          <= kind_reg_next;
        saw_cr            <= saw_cr_next;
        header_negative   <= header_negative_next;
        header_digit_seen <= header_digit_seen_next;
        header_value      <= header_value_next;
        payload_left      <= payload_left_next;
        items_left        <= items_left_next;
        frame_bytes       <= frame_bytes_next;
      end
    end
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (frame_info.ready) begin
      out_valid <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_done <= out_done_next;
      out_kind <= kind_reg_next;
      out_null <= out_null_next;
    end
  end

  assign frame_info.valid      = out_valid;
  assign frame_info.frame_done = out_done;
  assign frame_info.frame_kind = out_kind;
  assign frame_info.null_bulk  = out_null;
  assign frame_info.stuck      = stuck_flag;
  assign frame_info.oversize   = oversize_latch;

`ifndef NO_ASSERTIONS
  // oversize error holds until reset
  a_oversize_sticky: assert property (@(posedge clk) disable iff (rst)
    oversize_latch |=> oversize_latch)
    else $error("oversize latch cleared without reset");

  // a malformed frame stays stuck until reset
  a_stuck_sticky: assert property (@(posedge clk) disable iff (rst)
    stuck_flag |=> stuck_flag)
    else $error("stuck flag cleared without reset");

  // a completed frame is never stuck or oversize
  a_done_clean: assert property (@(posedge clk) disable iff (rst)
    (frame_info.valid && frame_info.frame_done) |-> (!frame_info.stuck && !frame_info.oversize))
    else $error("frame completed while stuck or oversize");

  // null marks only a completed bulk frame
  a_null_is_bulk: assert property (@(posedge clk) disable iff (rst)
    (frame_info.valid && frame_info.null_bulk)
      |-> (frame_info.frame_done && frame_info.frame_kind == rfbd_pkg::KIND_BULK))
    else $error("null bulk without completed bulk frame");

  // a held result blocks new bytes
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !frame_info.ready) |-> !byte_stream.ready)
    else $error("byte accepted while result register held");
`endif

endmodule

@@ dv/tb_top.sv @@
// testbench for the reply frame boundary detector: byte stimulus, status prediction, checks
`timescale 1ns / 100ps

module tb_top;

  localparam int NB = rfbd_pkg::NUMBER_BITS_DEF;
  localparam int BW = rfbd_pkg::BYTE_W;
  localparam longint unsigned NUM_MAX = (64'd1 << NB) - 64'd1;

  // register map: byte address is four times the register index
  localparam logic [rfbd_pkg::APB_ADDR_W-1:0] ADDR_MAX_FRAME_BYTES =
    {rfbd_pkg::REG_MAX_FRAME_BYTES, 2'b00};
  localparam logic [rfbd_pkg::APB_ADDR_W-1:0] ADDR_UNMAPPED =
    {~rfbd_pkg::REG_MAX_FRAME_BYTES, 2'b00};
  localparam logic [rfbd_pkg::APB_DATA_W-1:0] LIMIT_TOP = 32'd16777216;

  typedef enum int {HDR_MORE, HDR_BAD, HDR_END} hdr_step_t;

  typedef enum int {
    FAULT_TYPE_BYTE, FAULT_HDR_CHAR, FAULT_NO_DIGITS, FAULT_CR_NO_LF, FAULT_NEG_BULK,
    FAULT_NEG_COUNT, FAULT_NEG_ITEM, FAULT_ITEM_TYPE, FAULT_DOUBLE_MINUS, FAULT_HUGE_LEN
  } fault_t;

  typedef struct packed {
    logic                          done;
    logic [rfbd_pkg::KIND_W-1:0]   kind;
    logic                          null_bulk;
    logic                          stuck;
    logic                          oversize;
  } frame_status_t;

  typedef struct {
    rfbd_pkg::phase_t              ph;
    logic [rfbd_pkg::KIND_W-1:0]   kind;
    bit                            saw_cr;
    bit                            neg;
    bit                            digit_seen;
    logic [NB-1:0]                 hdr_val;
    logic [NB-1:0]                 payload_left;
    logic [NB-1:0]                 items_left;
    logic [rfbd_pkg::LIMIT_W-1:0]  frame_bytes;
    bit                            stuck;
    bit                            oversize;
  } parser_state_t;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [rfbd_pkg::APB_ADDR_W-1:0] paddr;
  logic [rfbd_pkg::APB_DATA_W-1:0] pwdata;
  logic [rfbd_pkg::APB_DATA_W-1:0] prdata;
  logic                            pready;

  rfbd_byte_if   byte_stream ();
  rfbd_result_if frame_info ();

  resp_frame_boundary_detector dut (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .byte_stream (byte_stream),
    .frame_info  (frame_info)
  );

  parser_state_t                  parser;
  logic [rfbd_pkg::LIMIT_W-1:0]   frame_limit;
  frame_status_t                  status_q[$];
  logic [BW-1:0]                  frame_q[$];
  int                             sender_gap_pct;
  int                             receiver_stall_pct;
  int                             bytes_sent;
  int                             mismatches;

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run limit
  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

  // ---------------------------------------------------------------- status predictor

  function automatic void clear_header();
    parser.saw_cr = 1'b0;
    parser.neg = 1'b0;
    parser.digit_seen = 1'b0;
    parser.hdr_val = '0;
  endfunction

  function automatic void clear_frame();
    parser.ph = rfbd_pkg::PH_TYPE;
    parser.kind = rfbd_pkg::KIND_SIMPLE;
    clear_header();
    parser.payload_left = '0;
    parser.items_left = '0;
    parser.frame_bytes = '0;
  endfunction

  function automatic void go_stuck();
    parser.stuck = 1'b1;
    parser.ph = rfbd_pkg::PH_STUCK;
  endfunction

  // payload plus two trailer bytes, saturating
  function automatic logic [NB-1:0] with_trailer(input logic [NB-1:0] v);
    longint unsigned w;
    w = 64'(v);
    return (w > NUM_MAX - 2) ? NUM_MAX[NB-1:0] : NB'(w + 2);
  endfunction

  // one byte of a decimal header: optional leading minus, digits, cr lf
  function automatic hdr_step_t header_step(input logic [BW-1:0] b);
    longint unsigned d;
    longint unsigned v;
    if (parser.saw_cr) begin
      if (b != rfbd_pkg::CH_LF || !parser.digit_seen) return HDR_BAD;
      return HDR_END;
    end
    if (b == rfbd_pkg::CH_CR) begin
      parser.saw_cr = 1'b1;
      return HDR_MORE;
    end
    if (b == rfbd_pkg::CH_MINUS && !parser.digit_seen && !parser.neg) begin
      parser.neg = 1'b1;
      return HDR_MORE;
    end
    if (b >= rfbd_pkg::CH_ZERO && b <= rfbd_pkg::CH_NINE) begin
      d = 64'(b - rfbd_pkg::CH_ZERO);
      v = 64'(parser.hdr_val);
      if (v > (NUM_MAX - d) / 10) parser.hdr_val = NUM_MAX[NB-1:0];
      else parser.hdr_val = NB'(v * 10 + d);
      parser.digit_seen = 1'b1;
      return HDR_MORE;
    end
    return HDR_BAD;
  endfunction

  // status that the block reports for one accepted byte
  function automatic frame_status_t predict_status(input logic [BW-1:0] b);
    frame_status_t r;
    hdr_step_t h;
    bit done;
    bit nul;
    done = 1'b0;
    nul = 1'b0;
    if (!parser.oversize) begin
      if (parser.frame_bytes >= frame_limit) begin
        parser.oversize = 1'b1;
      end else begin
        parser.frame_bytes = parser.frame_bytes + 1'b1;
        case (parser.ph) inside
          rfbd_pkg::PH_TYPE: begin
            clear_header();
            case (b)
              rfbd_pkg::CH_PLUS: begin
                parser.kind = rfbd_pkg::KIND_SIMPLE;
                parser.ph = rfbd_pkg::PH_LINE;
              end
              rfbd_pkg::CH_MINUS: begin
                parser.kind = rfbd_pkg::KIND_ERROR;
                parser.ph = rfbd_pkg::PH_LINE;
              end
              rfbd_pkg::CH_COLON: begin
                parser.kind = rfbd_pkg::KIND_INTEGER;
                parser.ph = rfbd_pkg::PH_LINE;
              end
              rfbd_pkg::CH_DOLLAR: begin
                parser.kind = rfbd_pkg::KIND_BULK;
                parser.ph = rfbd_pkg::PH_BULK_HDR;
              end
              rfbd_pkg::CH_STAR: begin
                parser.kind = rfbd_pkg::KIND_ARRAY;
                parser.ph = rfbd_pkg::PH_ARR_HDR;
              end
              default: begin
                parser.kind = rfbd_pkg::KIND_SIMPLE;
                go_stuck();
              end
            endcase
          end
          rfbd_pkg::PH_LINE: begin
            if (parser.saw_cr && b == rfbd_pkg::CH_LF) done = 1'b1;
            else parser.saw_cr = (b == rfbd_pkg::CH_CR);
          end
          rfbd_pkg::PH_BULK_HDR: begin
            h = header_step(b);
            if (h == HDR_BAD) begin
              go_stuck();
            end else if (h == HDR_END) begin
              if (parser.neg && parser.hdr_val == 1) begin
                done = 1'b1;
                nul = 1'b1;
              end else if (parser.neg && parser.hdr_val != 0) begin
                go_stuck();
              end else begin
                parser.payload_left = with_trailer(parser.hdr_val);
                parser.ph = rfbd_pkg::PH_BULK_BODY;
              end
            end
          end
          rfbd_pkg::PH_ARR_HDR, rfbd_pkg::PH_ITEM_HDR: begin
            h = header_step(b);
            if (h == HDR_BAD || (h == HDR_END && parser.neg && parser.hdr_val != 0)) begin
              go_stuck();
            end else if (h == HDR_END) begin
              if (parser.ph == rfbd_pkg::PH_ARR_HDR) begin
                parser.items_left = parser.hdr_val;
                if (parser.items_left == 0) done = 1'b1;
                else parser.ph = rfbd_pkg::PH_ITEM_TYPE;
              end else begin
                parser.payload_left = with_trailer(parser.hdr_val);
                parser.ph = rfbd_pkg::PH_ITEM_BODY;
              end
            end
          end
          rfbd_pkg::PH_ITEM_TYPE: begin
            clear_header();
            if (b == rfbd_pkg::CH_DOLLAR) parser.ph = rfbd_pkg::PH_ITEM_HDR;
            else go_stuck();
          end
          rfbd_pkg::PH_BULK_BODY, rfbd_pkg::PH_ITEM_BODY: begin
            if (parser.payload_left > 0) parser.payload_left = parser.payload_left - 1'b1;
            if (parser.payload_left == 0) begin
              if (parser.ph == rfbd_pkg::PH_BULK_BODY) begin
                done = 1'b1;
              end else begin
                if (parser.items_left > 0) parser.items_left = parser.items_left - 1'b1;
                if (parser.items_left == 0) done = 1'b1;
                else parser.ph = rfbd_pkg::PH_ITEM_TYPE;
              end
            end
          end
          default: go_stuck();
        endcase
      end
    end
    r.done = done;
    r.kind = parser.kind;
    r.null_bulk = nul;
    if (done) clear_frame();
    r.stuck = parser.stuck;
    r.oversize = parser.oversize;
    return r;
  endfunction

  // ---------------------------------------------------------------- drivers

  // register write over the apb port, called at a falling edge
  task automatic write_register(input logic [rfbd_pkg::APB_ADDR_W-1:0] addr,
                                input logic [rfbd_pkg::APB_DATA_W-1:0] data);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = addr;
    pwdata = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == ADDR_MAX_FRAME_BYTES) frame_limit = data[rfbd_pkg::LIMIT_W-1:0];
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // one byte transaction with random sender gaps; the status is predicted on acceptance
  task automatic send_byte(input logic [BW-1:0] b);
    while ($urandom_range(99) < sender_gap_pct) begin
      byte_stream.valid = 1'b0;
      @(negedge clk);
    end
    byte_stream.valid = 1'b1;
    byte_stream.data_byte = b;
    do @(posedge clk); while (!byte_stream.ready);
    status_q.insert(status_q.size(), predict_status(b));
    bytes_sent++;
    @(negedge clk);
    byte_stream.valid = 1'b0;
  endtask

  task automatic send_frame();
    while (frame_q.size() != 0) send_byte(frame_q.pop_front());
  endtask

  task automatic wait_for_statuses();
    while (status_q.size() != 0) @(negedge clk);
  endtask

  // receiver stalls
  initial begin
    frame_info.ready = 1'b0;
    forever begin
      @(negedge clk);
      frame_info.ready = ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // ---------------------------------------------------------------- frame builders

  function automatic void append_byte(input logic [BW-1:0] c);
    frame_q.insert(frame_q.size(), c);
  endfunction

  function automatic void push_crlf();
    append_byte(rfbd_pkg::CH_CR);
    append_byte(rfbd_pkg::CH_LF);
  endfunction

  function automatic void push_random(input int n);
    for (int i = 0; i < n; i++) append_byte(BW'($urandom_range(0, 255)));
  endfunction

  // decimal header value, optionally with a minus sign and leading zeros
  function automatic void push_number(input longint unsigned v, input bit neg, input bit pad);
    string s;
    s = $sformatf("%0d", v);
    if (neg) append_byte(rfbd_pkg::CH_MINUS);
    if (pad) repeat ($urandom_range(1, 2)) append_byte(rfbd_pkg::CH_ZERO);
    for (int i = 0; i < s.len(); i++) append_byte(s[i]);
  endfunction

  // length of zero is sometimes written as minus zero
  function automatic void push_length(input int n);
    push_number(n, n == 0 && $urandom_range(0, 3) == 0, $urandom_range(0, 4) == 0);
  endfunction

  function automatic void build_line();
    int n;
    logic [BW-1:0] c;
    case ($urandom_range(0, 2))
      0: append_byte(rfbd_pkg::CH_PLUS);
      1: append_byte(rfbd_pkg::CH_MINUS);
      default: append_byte(rfbd_pkg::CH_COLON);
    endcase
    n = $urandom_range(0, 12);
    for (int i = 0; i < n; i++) begin
      c = BW'($urandom_range(0, 255));
      // a lone cr is fine inside a line, but cr lf would end it early
      if ($urandom_range(0, 7) == 0) c = rfbd_pkg::CH_CR;
      if (c == rfbd_pkg::CH_LF) c = c ^ 8'h80;
      append_byte(c);
    end
    push_crlf();
  endfunction

  function automatic void build_bulk_body(input int n);
    push_length(n);
    push_crlf();
    push_random(n + 2);
  endfunction

  function automatic void build_bulk();
    append_byte(rfbd_pkg::CH_DOLLAR);
    if ($urandom_range(0, 7) == 0) begin
      push_number(1, 1'b1, 1'b0);
      push_crlf();
    end else begin
      build_bulk_body(($urandom_range(0, 15) == 0) ? $urandom_range(25, 100)
                                                   : $urandom_range(0, 24));
    end
  endfunction

  function automatic void build_array();
    int cnt;
    cnt = $urandom_range(0, 4);
    append_byte(rfbd_pkg::CH_STAR);
    push_length(cnt);
    push_crlf();
    for (int i = 0; i < cnt; i++) begin
      append_byte(rfbd_pkg::CH_DOLLAR);
      build_bulk_body($urandom_range(0, 12));
    end
  endfunction

  // ---------------------------------------------------------------- status checker

  always @(posedge clk) begin
    frame_status_t want;
    frame_status_t got;
    if (!rst && frame_info.valid && frame_info.ready) begin
      got.done = frame_info.frame_done;
      got.kind = frame_info.frame_kind;
      got.null_bulk = frame_info.null_bulk;
      got.stuck = frame_info.stuck;
      got.oversize = frame_info.oversize;
      if (status_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected status transaction done=%0b kind=%0d", $realtime,
                   got.done, got.kind);
      end else begin
        want = status_q.pop_front();
        if (got.done !== want.done || got.kind !== want.kind ||
            got.null_bulk !== want.null_bulk || got.stuck !== want.stuck ||
            got.oversize !== want.oversize) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: mismatch exp %0b/%0d/%0b/%0b/%0b got %0b/%0d/%0b/%0b/%0b",
                     $realtime, want.done, want.kind, want.null_bulk, want.stuck,
                     want.oversize, got.done, got.kind, got.null_bulk, got.stuck,
                     got.oversize);
        end
      end
    end
  end

  // ---------------------------------------------------------------- tests

  // one of each frame kind with the reset limit
  task automatic test_basic_frames();
    append_byte(rfbd_pkg::CH_PLUS);
    push_crlf();
    // error line with a lone cr inside
    append_byte(rfbd_pkg::CH_MINUS);
    append_byte(rfbd_pkg::CH_CR);
    append_byte(rfbd_pkg::CH_MINUS);
    push_crlf();
    append_byte(rfbd_pkg::CH_COLON);
    push_crlf();
    // null bulk
    append_byte(rfbd_pkg::CH_DOLLAR);
    push_number(1, 1'b1, 1'b0);
    push_crlf();
    // empty array completes at its header
    append_byte(rfbd_pkg::CH_STAR);
    push_number(0, 1'b0, 1'b0);
    push_crlf();
    // one item of length minus zero, trailer bytes at the byte extremes
    append_byte(rfbd_pkg::CH_STAR);
    push_number(1, 1'b0, 1'b0);
    push_crlf();
    append_byte(rfbd_pkg::CH_DOLLAR);
    push_number(0, 1'b1, 1'b0);
    push_crlf();
    append_byte(8'h00);
    append_byte(8'hFF);
    send_frame();
    wait_for_statuses();
  endtask

  // frames of exactly the limit size complete; a write to an unmapped index changes nothing
  task automatic test_limit_boundary();
    write_register(ADDR_MAX_FRAME_BYTES, 32'd8);
    append_byte(rfbd_pkg::CH_DOLLAR);
    push_number(2, 1'b0, 1'b0);
    push_crlf();
    push_random(4);
    send_frame();
    wait_for_statuses();
    write_register(ADDR_UNMAPPED, 32'd1);
    append_byte(rfbd_pkg::CH_DOLLAR);
    push_number(2, 1'b0, 1'b0);
    push_crlf();
    push_random(4);
    send_frame();
    wait_for_statuses();
  endtask

  task automatic run_random_frames(input int n_bytes);
    int start;
    start = bytes_sent;
    while (bytes_sent - start < n_bytes) begin
      case ($urandom_range(0, 9)) inside
        [0:2]: build_line();
        [3:6]: build_bulk();
        default: build_array();
      endcase
      send_frame();
    end
    wait_for_statuses();
  endtask

  task automatic test_random_traffic();
    write_register(ADDR_MAX_FRAME_BYTES, LIMIT_TOP);
    run_random_frames(620);
    sender_gap_pct = 57;
    receiver_stall_pct = 8;
    write_register(ADDR_MAX_FRAME_BYTES, $urandom_range(150, 400));
    run_random_frames(620);
    sender_gap_pct = 0;
    receiver_stall_pct = 0;
    write_register(ADDR_MAX_FRAME_BYTES, $urandom_range(150, 400));
    run_random_frames(600);
  endtask

  // stuck latches until reset, so only one malformed frame per run, then noise
  task automatic test_malformed_frame();
    fault_t f;
    logic [BW-1:0] c;
    f = fault_t'($urandom_range(0, 9));
    case (f)
      FAULT_TYPE_BYTE: begin
        do c = BW'($urandom_range(0, 255));
        while (c inside {rfbd_pkg::CH_PLUS, rfbd_pkg::CH_MINUS, rfbd_pkg::CH_COLON,
                         rfbd_pkg::CH_DOLLAR, rfbd_pkg::CH_STAR});
        append_byte(c);
      end
      FAULT_HDR_CHAR: begin
        append_byte($urandom_range(0, 1) ? rfbd_pkg::CH_DOLLAR : rfbd_pkg::CH_STAR);
        push_number($urandom_range(1, 9), 1'b0, 1'b0);
        do c = BW'($urandom_range(0, 255));
        while ((c >= rfbd_pkg::CH_ZERO && c <= rfbd_pkg::CH_NINE) || c == rfbd_pkg::CH_CR);
        append_byte(c);
      end
      FAULT_NO_DIGITS: begin
        append_byte(rfbd_pkg::CH_DOLLAR);
        push_crlf();
      end
      FAULT_CR_NO_LF: begin
        append_byte(rfbd_pkg::CH_DOLLAR);
        push_number(3, 1'b0, 1'b0);
        append_byte(rfbd_pkg::CH_CR);
        append_byte(rfbd_pkg::CH_CR);
      end
      FAULT_NEG_BULK: begin
        append_byte(rfbd_pkg::CH_DOLLAR);
        push_number($urandom_range(2, 9), 1'b1, 1'b0);
        push_crlf();
      end
      FAULT_NEG_COUNT: begin
        append_byte(rfbd_pkg::CH_STAR);
        push_number($urandom_range(1, 9), 1'b1, 1'b0);
        push_crlf();
      end
      FAULT_NEG_ITEM: begin
        append_byte(rfbd_pkg::CH_STAR);
        push_number(2, 1'b0, 1'b0);
        push_crlf();
        append_byte(rfbd_pkg::CH_DOLLAR);
        push_number(1, 1'b1, 1'b0);
        push_crlf();
      end
      FAULT_ITEM_TYPE: begin
        append_byte(rfbd_pkg::CH_STAR);
        push_number(1, 1'b0, 1'b0);
        push_crlf();
        append_byte(rfbd_pkg::CH_PLUS);
      end
      FAULT_DOUBLE_MINUS: begin
        append_byte(rfbd_pkg::CH_DOLLAR);
        append_byte(rfbd_pkg::CH_MINUS);
        append_byte(rfbd_pkg::CH_MINUS);
      end
      default: begin
        // length past the counter range saturates instead of wrapping to a short frame
        append_byte(rfbd_pkg::CH_DOLLAR);
        push_number(NUM_MAX + 1 + $urandom_range(0, 4), 1'b0, 1'b0);
        push_crlf();
      end
    endcase
    push_random(48);
    send_frame();
    wait_for_statuses();
  endtask

  // limit of one: the next byte latches oversize and everything freezes
  task automatic test_oversize_latch();
    write_register(ADDR_MAX_FRAME_BYTES,
                   {{(rfbd_pkg::APB_DATA_W-rfbd_pkg::LIMIT_W){1'b0}}, rfbd_pkg::LIMIT_ONE});
    push_random(16);
    append_byte(rfbd_pkg::CH_PLUS);
    push_crlf();
    send_frame();
    wait_for_statuses();
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    byte_stream.valid = 1'b0;
    byte_stream.data_byte = '0;
    sender_gap_pct = 8;
    receiver_stall_pct = 57;
    bytes_sent = 0;
    mismatches = 0;
    frame_limit = rfbd_pkg::LIMIT_RESET;
    parser.stuck = 1'b0;
    parser.oversize = 1'b0;
    clear_frame();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_basic_frames();
    test_limit_boundary();
    test_random_traffic();
    test_malformed_frame();
    test_oversize_latch();

    repeat (4) @(negedge clk);
    if (mismatches == 0 && status_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/rfbd_pkg.sv
hdl/rfbd_byte_if.sv
hdl/rfbd_result_if.sv
hdl/resp_frame_boundary_detector.sv
dv/tb_top.sv
